@@ sv/ffa_pkg.sv @@
`timescale 1ns / 1ps

package ffa_pkg;

    // Default heap capacity in 8-byte granules and largest allocation in bytes
    localparam int HEAP_GRANULES   = 16384;
    localparam int MAX_ALLOC_BYTES = 65536;

    // Heap size after reset, in granules
    localparam int RESET_HEAP_GRANULES = 131072 / 8;

    // Block overhead (32-byte header plus 16-byte footer) and smallest split remainder
    localparam int OVERHEAD_GRANULES  = 6;
    localparam int MIN_SPLIT_GRANULES = 7;
    localparam int PAYLOAD_OFFSET     = 32;

    // Width of a rounded request in granules, including overhead
    localparam int NEED_W = 18;

    // Configuration register indexes
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_BYTES = 1'b1;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
    localparam logic [2:0] ST_NO_FIT     = 3'd2;
    localparam logic [2:0] ST_NOT_BLOCK  = 3'd3;
    localparam logic [2:0] ST_DOUBLE     = 3'd4;
    localparam logic [2:0] ST_HEAP_SMALL = 3'd5;

    typedef struct packed {
        logic        operation;
        logic [19:0] request_size;
        logic [47:0] free_address;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] payload_address;
        logic [17:0] used_bytes;
        logic [17:0] free_bytes;
    } out_t;

endpackage

@@ sv/ffa_mem.sv @@
`timescale 1ns / 1ps

module ffa_mem #(
    parameter int DEPTH = ffa_pkg::HEAP_GRANULES,
    parameter int WIDTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/first_fit_heap_allocator_top.sv @@
`timescale 1ns / 1ps

// First-fit heap allocator with boundary tags.
// Input channel (in_valid/in_ready/in_data) takes one allocate or free request
// per transfer; output channel (out_valid/out_ready/out_data) returns exactly one
// result per request: status, payload address, used and free byte counts.
// Configuration port: cfg_we writes cfg_data into register cfg_index
// (0 heap base, 1 heap size). Writing the heap size reformats the heap.
// Block headers and footers live in two single-port-write synchronous memories
// with registered reads; the sequencer reads, updates and writes back.
// Accesses are ordered so that no read targets an entry with a write in flight.
// An allocate reads and checks each block visited on the first-fit walk, plus
// a split step when it cuts a block; a free checks the header and merges with a
// free next or previous block; a rejected size or a request against a missing heap
// skips the walk; then the output register loads. One request is in work at a time.
// Reset and each heap size write start a clearing pass over the heap granules of
// both memories, then an init step, during which in_ready stays low.
// When the receiver stalls, the finished result holds in the output register;
// the next request is taken meanwhile and its result waits until that one drains.
module first_fit_heap_allocator_top #(
    parameter int HEAP_GRANULES   = ffa_pkg::HEAP_GRANULES,
    parameter int MAX_ALLOC_BYTES = ffa_pkg::MAX_ALLOC_BYTES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ffa_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ffa_pkg::out_t  out_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [47:0]    cfg_data
);

    localparam int GW = $clog2(HEAP_GRANULES);
    localparam int SW = GW + 1;
    localparam int HW = SW + 2;
    localparam int FW = SW + 1;
    localparam int NW = ffa_pkg::NEED_W;
    localparam int CW = ((SW > NW) ? SW : NW) + 1;
    localparam logic [SW-1:0] RESET_TOTAL =
        (ffa_pkg::RESET_HEAP_GRANULES > HEAP_GRANULES) ? SW'(HEAP_GRANULES)
                                                      : SW'(ffa_pkg::RESET_HEAP_GRANULES);

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_INIT  = 16'h0002,
        S_IDLE  = 16'h0004,
        S_A_RD  = 16'h0008,
        S_A_CHK = 16'h0010,
        S_A_SPL = 16'h0020,
        S_F_OFF = 16'h0040,
        S_F_HDR = 16'h0080,
        S_F_NXT = 16'h0100,
        S_F_NX2 = 16'h0200,
        S_F_PRD = 16'h0400,
        S_F_PFT = 16'h0800,
        S_F_PHD = 16'h1000,
        S_F_PM2 = 16'h2000,
        S_RESP  = 16'h4000,
        S_SPARE = 16'h8000
    } state_t;

    state_t           state_reg, state_next;
    logic [SW-1:0]    total_reg, total_next;
    logic [SW-1:0]    used_reg, used_next;
    logic [47:0]      base_reg, base_next;
    logic [SW-1:0]    clr_reg, clr_next;
    logic [SW-1:0]    g_reg, g_next;
    logic [SW-1:0]    s_reg, s_next;
    logic [SW-1:0]    ps_reg, ps_next;
    logic [NW-1:0]    need_reg, need_next;
    logic [47:0]      faddr_reg, faddr_next;
    logic [2:0]       status_reg, status_next;
    logic [47:0]      addr_reg, addr_next;
    logic             out_valid_reg, out_valid_next;
    ffa_pkg::out_t    out_reg, out_next;

    logic             hdr_we, ftr_we;
    logic [GW-1:0]    hdr_waddr, hdr_raddr, ftr_waddr, ftr_raddr;
    logic [HW-1:0]    hdr_wdata, hdr_rdata;
    logic [FW-1:0]    ftr_wdata, ftr_rdata;

    logic             heap_ok;
    logic [20:0]      req_round;
    logic [NW-1:0]    req_need;
    logic             req_bad;
    logic [14:0]      cfg_gran;
    logic [SW-1:0]    cfg_total;
    logic             h_valid, h_free, f_valid;
    logic [SW-1:0]    h_size, f_size;
    logic [SW:0]      g_plus_s, g_plus_hs;
    logic [47:0]      off;
    logic             off_ok;
    logic [SW-1:0]    s_sum;

    ffa_mem #(.DEPTH(HEAP_GRANULES), .WIDTH(HW)) u_hdr_mem (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (hdr_waddr),
        .wdata (hdr_wdata),
        .raddr (hdr_raddr),
        .rdata (hdr_rdata)
    );

    ffa_mem #(.DEPTH(HEAP_GRANULES), .WIDTH(FW)) u_ftr_mem (
        .clk   (clk),
        .we    (ftr_we),
        .waddr (ftr_waddr),
        .wdata (ftr_wdata),
        .raddr (ftr_raddr),
        .rdata (ftr_rdata)
    );

    assign heap_ok   = (total_reg >= SW'(ffa_pkg::OVERHEAD_GRANULES));
    assign req_round = (21'(in_data.request_size) + 21'd7) >> 3;
    assign req_need  = NW'(req_round) + NW'(ffa_pkg::OVERHEAD_GRANULES);
    assign req_bad   = (in_data.request_size == 20'd0) ||
                       (21'(in_data.request_size) > 21'(MAX_ALLOC_BYTES));

    // Clamp the configured size to the store depth
    assign cfg_gran  = cfg_data[17:3];
    assign cfg_total = (21'(cfg_gran) > 21'(HEAP_GRANULES)) ? SW'(HEAP_GRANULES)
                                                            : SW'(cfg_gran);

    assign h_valid   = hdr_rdata[SW+1];
    assign h_free    = hdr_rdata[SW];
    assign h_size    = hdr_rdata[SW-1:0];
    assign f_valid   = ftr_rdata[SW];
    assign f_size    = ftr_rdata[SW-1:0];
    assign g_plus_s  = (SW+1)'(g_reg) + (SW+1)'(s_reg);
    assign g_plus_hs = (SW+1)'(g_reg) + (SW+1)'(h_size);
    assign s_sum     = s_reg + h_size;

    // Payload offset back to a granule index
    assign off    = faddr_reg - base_reg - 48'(ffa_pkg::PAYLOAD_OFFSET);
    assign off_ok = (off[2:0] == 3'd0) && (off[47:3] < 45'(total_reg));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        used_next      = used_reg;
        base_next      = base_reg;
        clr_next       = clr_reg;
        g_next         = g_reg;
        s_next         = s_reg;
        ps_next        = ps_reg;
        need_next      = need_reg;
        faddr_next     = faddr_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        hdr_we         = 1'b0;
        ftr_we         = 1'b0;
        hdr_waddr      = g_reg[GW-1:0];
        ftr_waddr      = g_reg[GW-1:0];
        hdr_wdata      = '0;
        ftr_wdata      = '0;
        hdr_raddr      = g_reg[GW-1:0];
        ftr_raddr      = g_reg[GW-1:0];

        // Drain the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Wipe every tag of the heap, one granule a cycle
                if (clr_reg < total_reg)
                begin
                    hdr_we    = 1'b1;
                    ftr_we    = 1'b1;
                    hdr_waddr = clr_reg[GW-1:0];
                    ftr_waddr = clr_reg[GW-1:0];
                    clr_next  = clr_reg + SW'(1);
                end
                else
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (heap_ok)
                begin
                    hdr_we    = 1'b1;
                    hdr_waddr = '0;
                    hdr_wdata = {1'b1, 1'b1, total_reg};
                    ftr_we    = 1'b1;
                    ftr_waddr = GW'(total_reg - SW'(1));
                    ftr_wdata = {1'b1, total_reg};
                end
                used_next  = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    need_next  = req_need;
                    faddr_next = in_data.free_address;
                    addr_next  = '0;
                    g_next     = '0;
                    status_next = ffa_pkg::ST_OK;
                    if (!heap_ok)
                    begin
                        status_next = ffa_pkg::ST_HEAP_SMALL;
                        state_next  = S_RESP;
                    end
                    else if (in_data.operation == ffa_pkg::OP_FREE)
                    begin
                        state_next = S_F_OFF;
                    end
                    else if (req_bad)
                    begin
                        status_next = ffa_pkg::ST_BAD_SIZE;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_A_RD;
                    end
                end
            end
            S_A_RD:
            begin
                hdr_raddr  = g_reg[GW-1:0];
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (!h_valid)
                begin
                    status_next = ffa_pkg::ST_NO_FIT;
                    state_next  = S_RESP;
                end
                else if (h_free && (CW'(h_size) >= CW'(need_reg)))
                begin
                    if ((CW'(h_size) - CW'(need_reg)) >= CW'(ffa_pkg::MIN_SPLIT_GRANULES))
                    begin
                        // Carve the tail off as a new free block
                        hdr_we     = 1'b1;
                        hdr_waddr  = GW'(g_reg + SW'(need_reg));
                        hdr_wdata  = {1'b1, 1'b1, SW'(h_size - SW'(need_reg))};
                        ftr_we     = 1'b1;
                        ftr_waddr  = GW'(g_plus_hs - (SW+1)'(1));
                        ftr_wdata  = {1'b1, SW'(h_size - SW'(need_reg))};
                        s_next     = SW'(need_reg);
                        state_next = S_A_SPL;
                    end
                    else
                    begin
                        hdr_we      = 1'b1;
                        hdr_wdata   = {1'b1, 1'b0, h_size};
                        ftr_we      = 1'b1;
                        ftr_waddr   = GW'(g_plus_hs - (SW+1)'(1));
                        ftr_wdata   = {1'b1, h_size};
                        used_next   = used_reg + h_size;
                        addr_next   = base_reg + {(48-SW-3)'(0), g_reg, 3'b000}
                                      + 48'(ffa_pkg::PAYLOAD_OFFSET);
                        state_next  = S_RESP;
                    end
                end
                else if ((h_size == '0) || (g_plus_hs >= (SW+1)'(total_reg)))
                begin
                    status_next = ffa_pkg::ST_NO_FIT;
                    state_next  = S_RESP;
                end
                else
                begin
                    g_next     = SW'(g_plus_hs);
                    state_next = S_A_RD;
                end
            end
            S_A_SPL:
            begin
                hdr_we     = 1'b1;
                hdr_wdata  = {1'b1, 1'b0, s_reg};
                ftr_we     = 1'b1;
                ftr_waddr  = GW'(g_plus_s - (SW+1)'(1));
                ftr_wdata  = {1'b1, s_reg};
                used_next  = used_reg + s_reg;
                addr_next  = base_reg + {(48-SW-3)'(0), g_reg, 3'b000}
                             + 48'(ffa_pkg::PAYLOAD_OFFSET);
                state_next = S_RESP;
            end
            S_F_OFF:
            begin
                if (faddr_reg == '0)
                begin
                    state_next = S_RESP;
                end
                else if (!off_ok)
                begin
                    status_next = ffa_pkg::ST_NOT_BLOCK;
                    state_next  = S_RESP;
                end
                else
                begin
                    g_next     = off[SW+2:3];
                    hdr_raddr  = off[GW+2:3];
                    state_next = S_F_HDR;
                end
            end
            S_F_HDR:
            begin
                if (!h_valid)
                begin
                    status_next = ffa_pkg::ST_NOT_BLOCK;
                    state_next  = S_RESP;
                end
                else if (h_free)
                begin
                    status_next = ffa_pkg::ST_DOUBLE;
                    state_next  = S_RESP;
                end
                else
                begin
                    s_next    = h_size;
                    used_next = used_reg - h_size;
                    hdr_we    = 1'b1;
                    hdr_wdata = {1'b1, 1'b1, h_size};
                    // Fetch the next block's header if it lies inside the heap
                    hdr_raddr = GW'(g_plus_hs);
                    if (g_plus_hs < (SW+1)'(total_reg))
                    begin
                        state_next = S_F_NXT;
                    end
                    else
                    begin
                        state_next = S_F_PRD;
                    end
                end
            end
            S_F_NXT:
            begin
                if (h_valid && h_free)
                begin
                    // Absorb the next block: drop its header and our old footer
                    hdr_we     = 1'b1;
                    hdr_waddr  = GW'(g_plus_s);
                    ftr_we     = 1'b1;
                    ftr_waddr  = GW'(g_plus_s - (SW+1)'(1));
                    s_next     = s_sum;
                    state_next = S_F_NX2;
                end
                else
                begin
                    state_next = S_F_PRD;
                end
            end
            S_F_NX2:
            begin
                hdr_we     = 1'b1;
                hdr_wdata  = {1'b1, 1'b1, s_reg};
                ftr_we     = 1'b1;
                ftr_waddr  = GW'(g_plus_s - (SW+1)'(1));
                ftr_wdata  = {1'b1, s_reg};
                state_next = S_F_PRD;
            end
            S_F_PRD:
            begin
                ftr_raddr = GW'(g_reg - SW'(1));
                if (g_reg != '0)
                begin
                    state_next = S_F_PFT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_F_PFT:
            begin
                hdr_raddr = GW'(g_reg - f_size);
                if (f_valid && (f_size != '0) && (f_size <= g_reg))
                begin
                    ps_next    = f_size;
                    state_next = S_F_PHD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_F_PHD:
            begin
                if (h_valid && h_free)
                begin
                    // Fold into the previous block: drop our header and its footer
                    hdr_we     = 1'b1;
                    ftr_we     = 1'b1;
                    ftr_waddr  = GW'(g_reg - SW'(1));
                    state_next = S_F_PM2;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_F_PM2:
            begin
                hdr_we     = 1'b1;
                hdr_waddr  = GW'(g_reg - ps_reg);
                hdr_wdata  = {1'b1, 1'b1, SW'(ps_reg + s_reg)};
                ftr_we     = 1'b1;
                ftr_waddr  = GW'(g_plus_s - (SW+1)'(1));
                ftr_wdata  = {1'b1, SW'(ps_reg + s_reg)};
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status          = status_reg;
                    out_next.payload_address = addr_reg;
                    out_next.used_bytes      = heap_ok ? 18'({used_reg, 3'b000}) : '0;
                    out_next.free_bytes      = heap_ok ? 18'({SW'(total_reg - used_reg), 3'b000})
                                                       : '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Register writes must come only between requests, unchecked; a size write restarts the clear
        if (cfg_we)
        begin
            unique case (cfg_index)
                ffa_pkg::REG_HEAP_BASE:
                begin
                    base_next = cfg_data;
                end
                ffa_pkg::REG_HEAP_BYTES:
                begin
                    total_next = cfg_total;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            total_reg     <= RESET_TOTAL;
            used_reg      <= '0;
            base_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            used_reg      <= used_next;
            base_reg      <= base_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg      <= g_next;
        s_reg      <= s_next;
        ps_reg     <= ps_next;
        need_reg   <= need_next;
        faddr_reg  <= faddr_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
        out_reg    <= out_next;
    end

endmodule

@@ sv/ffa_checker.sv @@
`timescale 1ns / 1ps

module ffa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input ffa_pkg::out_t out_data
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Status stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ffa_pkg::ST_HEAP_SMALL)
        else $error("undefined status code");

    // Any failure returns a null address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ffa_pkg::ST_OK |-> out_data.payload_address == '0)
        else $error("address on failed request");

    // No heap means nothing counted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ffa_pkg::ST_HEAP_SMALL
        |-> out_data.used_bytes == '0 && out_data.free_bytes == '0)
        else $error("counts reported without a heap");

    // No request is taken at the first edge out of reset; the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !(in_valid && in_ready))
        else $error("request taken during clearing pass");

endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
